// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RVQ_ASSERT_IMPLY(name, ck, rn, a, c) \
    name: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define RVQ_ASSERT_NEXT(name, ck, rn, a, c) \
    name: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/rvq_pkg.sv =====
package rvq_pkg;

    localparam int AXES = 3;

    typedef struct packed {
        logic valid;
        logic zero;
        logic neg;
    } rvq_tag_t;

endpackage

// ===== rtl/core/rotate_vector_by_quaternion.sv =====
// Pipeline: six arithmetic stages, then one restoring division stage per
// quotient bit (VEC_WIDTH + 1), then the output register; accepts one word
// per cycle while the output is not stalled.
// A stall on the output freezes the whole pipeline.
// Reset (rst_n low, asynchronous) clears all valid bits; the pipeline empties.
module rotate_vector_by_quaternion #(
    parameter int VEC_WIDTH  = 32,
    parameter int QUAT_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z, zero pad
    input  logic [((3*VEC_WIDTH+4*QUAT_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // rot_x, rot_y, rot_z, saturated, zero_norm, zero pad
    output logic [((3*VEC_WIDTH+2+7)/8)*8-1:0] m_tdata
);
    import rvq_pkg::*;
    `include "assert_macros.svh"

    localparam int VW  = VEC_WIDTH;
    localparam int QW  = QUAT_WIDTH;
    localparam int H   = VW / 2;
    localparam int PW  = 2 * QW;
    localparam int NW  = 2 * QW + 1;
    localparam int MW  = 2 * QW + 2;
    localparam int LW  = MW + H + 1;
    localparam int HW  = MW + VW - H;
    localparam int TW  = MW + VW;
    localparam int SW  = TW + 2;
    localparam int DW  = SW + 1;
    localparam int DVW = NW + 1;
    localparam int QB  = VW + 1;
    localparam int OW  = ((3*VW+2+7)/8)*8;
    localparam logic [QB-1:0] LIM_NEG = QB'(1) << (VW - 1);
    localparam logic [QB-1:0] LIM_POS = LIM_NEG - QB'(1);
    localparam logic [VW-1:0] MAXV = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] MINV = {1'b1, {(VW-1){1'b0}}};

    logic en;
    logic val1_reg, val2_reg, val3_reg, val4_reg, val5_reg;
    logic zero2_reg, zero3_reg, zero4_reg, zero5_reg;

    logic signed [VW-1:0] vin [AXES];
    logic signed [QW-1:0] qw, qx, qy, qz;
    logic signed [PW-1:0] pr_next [10];
    logic signed [PW-1:0] pr_reg [10];
    logic signed [VW-1:0] v1_reg [AXES];
    logic signed [VW-1:0] v2_reg [AXES];

    logic signed [MW-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz, nsum;
    logic signed [MW-1:0] m_next [AXES][AXES];
    logic signed [MW-1:0] m_reg [AXES][AXES];
    logic [NW-1:0] n2_reg, n3_reg, n4_reg, n5_reg;

    logic signed [LW-1:0] plo_reg [AXES][AXES];
    logic signed [HW-1:0] phi_reg [AXES][AXES];
    logic signed [TW-1:0] t_reg [AXES][AXES];
    logic signed [SW-1:0] s_reg [AXES];

    logic [DW-1:0]  dvd_reg [AXES];
    logic [DVW-1:0] dvs_reg;
    rvq_tag_t       tag6_reg [AXES];

    logic [QB-1:0] q_w [AXES];
    rvq_tag_t      tag_w [AXES];

    logic [VW-1:0] rot_next [AXES];
    logic [VW-1:0] rot_reg [AXES];
    logic          sat_next, sat_reg, zn_reg, out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            vin[k] = s_tdata[k*VW +: VW];
        end
        qw = s_tdata[3*VW +: QW];
        qx = s_tdata[3*VW+QW +: QW];
        qy = s_tdata[3*VW+2*QW +: QW];
        qz = s_tdata[3*VW+3*QW +: QW];
        pr_next[0] = qw * qw;
        pr_next[1] = qx * qx;
        pr_next[2] = qy * qy;
        pr_next[3] = qz * qz;
        pr_next[4] = qx * qy;
        pr_next[5] = qx * qz;
        pr_next[6] = qy * qz;
        pr_next[7] = qw * qx;
        pr_next[8] = qw * qy;
        pr_next[9] = qw * qz;
    end

    always_comb
    begin
        ww = MW'(pr_reg[0]);
        xx = MW'(pr_reg[1]);
        yy = MW'(pr_reg[2]);
        zz = MW'(pr_reg[3]);
        xy = MW'(pr_reg[4]);
        xz = MW'(pr_reg[5]);
        yz = MW'(pr_reg[6]);
        wx = MW'(pr_reg[7]);
        wy = MW'(pr_reg[8]);
        wz = MW'(pr_reg[9]);
        nsum = ww + xx + yy + zz;
        m_next[0][0] = ww + xx - yy - zz;
        m_next[0][1] = (xy - wz) <<< 1;
        m_next[0][2] = (xz + wy) <<< 1;
        m_next[1][0] = (xy + wz) <<< 1;
        m_next[1][1] = ww + yy - xx - zz;
        m_next[1][2] = (yz - wx) <<< 1;
        m_next[2][0] = (xz - wy) <<< 1;
        m_next[2][1] = (yz + wx) <<< 1;
        m_next[2][2] = ww + zz - xx - yy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val1_reg      <= 1'b0;
            val2_reg      <= 1'b0;
            val3_reg      <= 1'b0;
            val4_reg      <= 1'b0;
            val5_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            val1_reg      <= s_tvalid;
            val2_reg      <= val1_reg;
            val3_reg      <= val2_reg;
            val4_reg      <= val3_reg;
            val5_reg      <= val4_reg;
            out_valid_reg <= tag_w[0].valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                tag6_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                tag6_reg[k].valid <= val5_reg;
                tag6_reg[k].zero  <= zero5_reg;
                tag6_reg[k].neg   <= s_reg[k][SW-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg    <= pr_next;
            v1_reg    <= vin;
            v2_reg    <= v1_reg;
            m_reg     <= m_next;
            n2_reg    <= nsum[NW-1:0];
            zero2_reg <= (nsum == '0);
            n3_reg    <= n2_reg;
            zero3_reg <= zero2_reg;
            n4_reg    <= n3_reg;
            zero4_reg <= zero3_reg;
            n5_reg    <= n4_reg;
            zero5_reg <= zero4_reg;
            dvs_reg   <= {n5_reg, 1'b0};
            for (int i = 0; i < AXES; i++)
            begin
                for (int j = 0; j < AXES; j++)
                begin
                    plo_reg[i][j] <= m_reg[i][j] * $signed({1'b0, v2_reg[j][H-1:0]});
                    phi_reg[i][j] <= m_reg[i][j] * $signed(v2_reg[j][VW-1:H]);
                    t_reg[i][j]   <= (TW'(phi_reg[i][j]) <<< H) + TW'(plo_reg[i][j]);
                end
                s_reg[i] <= SW'(t_reg[i][0]) + SW'(t_reg[i][1]) + SW'(t_reg[i][2]);
                dvd_reg[i] <= DW'({(s_reg[i][SW-1] ? -s_reg[i] : s_reg[i]), 1'b0})
                            + DW'(n5_reg);
            end
            rot_reg <= rot_next;
            sat_reg <= sat_next;
            zn_reg  <= tag_w[0].zero;
        end
    end

    for (genvar k = 0; k < AXES; k++) begin : g_div
        rvq_div #(
            .DW  (DW),
            .DVW (DVW),
            .QB  (QB)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .dividend (dvd_reg[k]),
            .divisor  (dvs_reg),
            .tag_in   (tag6_reg[k]),
            .quotient (q_w[k]),
            .tag_out  (tag_w[k])
        );
    end

    // round-half-away quotient to saturated signed result; zero norm gives zero
    always_comb
    begin
        sat_next = 1'b0;
        for (int k = 0; k < AXES; k++)
        begin
            if (tag_w[k].zero)
            begin
                rot_next[k] = '0;
            end
            else if (tag_w[k].neg)
            begin
                if (q_w[k] > LIM_NEG)
                begin
                    rot_next[k] = MINV;
                    sat_next    = 1'b1;
                end
                else
                begin
                    rot_next[k] = VW'(-q_w[k]);
                end
            end
            else
            begin
                if (q_w[k] > LIM_POS)
                begin
                    rot_next[k] = MAXV;
                    sat_next    = 1'b1;
                end
                else
                begin
                    rot_next[k] = q_w[k][VW-1:0];
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OW'({zn_reg, sat_reg, rot_reg[2], rot_reg[1], rot_reg[0]});

    `RVQ_ASSERT_IMPLY(a_zero_norm_out, clk, rst_n, m_tvalid && zn_reg,
        !sat_reg && rot_reg[0] == '0 && rot_reg[1] == '0 && rot_reg[2] == '0)
    `RVQ_ASSERT_IMPLY(a_sat_at_bound, clk, rst_n, m_tvalid && sat_reg,
        rot_reg[0] == MAXV || rot_reg[0] == MINV || rot_reg[1] == MAXV ||
        rot_reg[1] == MINV || rot_reg[2] == MAXV || rot_reg[2] == MINV)
    `RVQ_ASSERT_NEXT(a_stall_holds, clk, rst_n, !en,
        $stable(dvd_reg[0]) && $stable(q_w[0]) && $stable(tag_w[0]))

endmodule

// ===== rtl/core/rvq_div.sv =====
module rvq_div #(
    parameter int DW  = 69,
    parameter int DVW = 34,
    parameter int QB  = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [DW-1:0]    dividend,
    input  logic [DVW-1:0]   divisor,
    input  rvq_pkg::rvq_tag_t tag_in,
    output logic [QB-1:0]    quotient,
    output rvq_pkg::rvq_tag_t tag_out
);
    import rvq_pkg::*;

    logic [DW-1:0]  rem_c [QB+1];
    logic [DVW-1:0] dvs_c [QB+1];
    logic [QB-1:0]  quo_c [QB+1];
    rvq_tag_t       tag_c [QB+1];

    assign rem_c[0] = dividend;
    assign dvs_c[0] = divisor;
    assign quo_c[0] = '0;
    assign tag_c[0] = tag_in;

    // one quotient bit per stage, MSB first
    for (genvar i = 0; i < QB; i++) begin : g_stage
        localparam int B = QB - 1 - i;
        logic [DW-1:0] sd;
        logic          ge;

        assign sd = DW'(dvs_c[i]) << B;
        assign ge = (rem_c[i] >= sd);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_c[i+1] <= '0;
            end
            else if (en)
            begin
                tag_c[i+1] <= tag_c[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_c[i+1] <= ge ? (rem_c[i] - sd) : rem_c[i];
                dvs_c[i+1] <= dvs_c[i];
                quo_c[i+1] <= quo_c[i] | (QB'(ge) << B);
            end
        end
    end

    assign quotient = quo_c[QB];
    assign tag_out  = tag_c[QB];

endmodule

// ===== tb/rotate_vector_by_quaternion_tb.sv =====
module rotate_vector_by_quaternion_tb;

    localparam int VW = 32;
    localparam int QW = 16;
    localparam int SW = ((3*VW+4*QW+7)/8)*8;
    localparam int MW = ((3*VW+2+7)/8)*8;
    localparam int LIMIT = 400000;

    typedef struct {
        logic signed [VW-1:0] vx, vy, vz;
        logic signed [QW-1:0] qw, qx, qy, qz;
    } rot_in_t;

    typedef struct {
        logic signed [VW-1:0] rx, ry, rz;
        logic sat;
        logic zn;
    } rot_out_t;

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [MW-1:0] m_tdata;

    rot_out_t expected_rot[$];
    int errors = 0;
    int cycles = 0;
    bit idle_on = 1;
    int hold_cycles = 0;

    rotate_vector_by_quaternion #(.VEC_WIDTH(VW), .QUAT_WIDTH(QW)) dut (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic signed [VW-1:0] round_div_sat(logic signed [255:0] num,
                                                           logic signed [255:0] nrm,
                                                           inout logic clip);
        logic signed [255:0] mag, q;
        logic signed [255:0] hi, lo;
        hi = (256'sd1 <<< (VW-1)) - 1;
        lo = -(256'sd1 <<< (VW-1));
        mag = (num < 0) ? -num : num;
        q = (2*mag + nrm) / (2*nrm);
        if (num < 0)
            q = -q;
        if (q > hi)
        begin
            clip = 1;
            return hi[VW-1:0];
        end
        if (q < lo)
        begin
            clip = 1;
            return lo[VW-1:0];
        end
        return q[VW-1:0];
    endfunction

    function automatic rot_out_t rotate(rot_in_t a);
        rot_out_t r;
        logic signed [255:0] w, x, y, z, n, m[3][3], v[3], num;
        logic signed [VW-1:0] res[3];
        logic clip;
        w = a.qw; x = a.qx; y = a.qy; z = a.qz;
        v[0] = a.vx; v[1] = a.vy; v[2] = a.vz;
        n = w*w + x*x + y*y + z*z;
        r = '{default: '0};
        if (n == 0)
        begin
            r.zn = 1;
            return r;
        end
        m[0][0] = w*w + x*x - y*y - z*z;
        m[0][1] = 2*(x*y - w*z);
        m[0][2] = 2*(x*z + w*y);
        m[1][0] = 2*(x*y + w*z);
        m[1][1] = w*w + y*y - x*x - z*z;
        m[1][2] = 2*(y*z - w*x);
        m[2][0] = 2*(x*z - w*y);
        m[2][1] = 2*(y*z + w*x);
        m[2][2] = w*w + z*z - x*x - y*y;
        clip = 0;
        for (int i = 0; i < 3; i++)
        begin
            num = m[i][0]*v[0] + m[i][1]*v[1] + m[i][2]*v[2];
            res[i] = round_div_sat(num, n, clip);
        end
        r.rx = res[0]; r.ry = res[1]; r.rz = res[2];
        r.sat = clip;
        return r;
    endfunction

    task automatic report(string what, logic [VW-1:0] got, logic [VW-1:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic send_word(rot_in_t a);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= {a.qz, a.qy, a.qx, a.qw, a.vz, a.vy, a.vx};
        s_tvalid <= 1;
        do @(posedge clk); while (!s_tready);
        expected_rot.push_back(rotate(a));
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            rot_out_t e;
            if (expected_rot.size() == 0)
            begin
                report("unexpected word", m_tdata[VW-1:0], 0);
            end
            else
            begin
                e = expected_rot.pop_front();
                if (m_tdata[VW-1:0] !== e.rx) report("rot_x", m_tdata[VW-1:0], e.rx);
                if (m_tdata[2*VW-1:VW] !== e.ry) report("rot_y", m_tdata[2*VW-1:VW], e.ry);
                if (m_tdata[3*VW-1:2*VW] !== e.rz)
                    report("rot_z", m_tdata[3*VW-1:2*VW], e.rz);
                if (m_tdata[3*VW] !== e.sat) report("saturated", m_tdata[3*VW], e.sat);
                if (m_tdata[3*VW+1] !== e.zn) report("zero_norm", m_tdata[3*VW+1], e.zn);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
            m_tready <= 0;
        else
            m_tready <= 1;
    end

    function automatic rot_in_t rand_word(bit unit_ish);
        rot_in_t a;
        a.vx = $urandom; a.vy = $urandom; a.vz = $urandom;
        if ($urandom_range(0, 2) == 0)
        begin
            a.vx = $signed(a.vx) >>> 12; a.vy = $signed(a.vy) >>> 12;
            a.vz = $signed(a.vz) >>> 12;
        end
        a.qw = QW'($urandom); a.qx = QW'($urandom);
        a.qy = QW'($urandom); a.qz = QW'($urandom);
        if (unit_ish)
        begin
            a.qw = $signed(a.qw) >>> 1; a.qx = $signed(a.qx) >>> 2;
            a.qy = $signed(a.qy) >>> 2; a.qz = $signed(a.qz) >>> 2;
        end
        if ($urandom_range(0, 30) == 0)
            a.qw = 0;
        return a;
    endfunction

    task automatic test_directed();
        rot_in_t a;
        logic signed [VW-1:0] vext[4] = '{32'sh7fffffff, 32'sh80000000, 32'sh00010000, 0};
        logic signed [QW-1:0] qext[4] = '{16'sh7fff, 16'sh8000, 16'sh4000, 0};
        // identity, zero quaternion, extremes, a 90 and a 180 degree turn, tiny quaternion
        a = '{32'sh00010000, 32'sh00020000, 32'sh00030000, 16'sh4000, 0, 0, 0};
        send_word(a);
        a.qw = 0;
        send_word(a);
        a = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sh2d41, 16'sh2d41, 0, 0};
        send_word(a);
        a = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh7fff};
        send_word(a);
        a = '{32'sh00010000, 0, 0, 0, 0, 0, 16'sh4000};
        send_word(a);
        a = '{32'sh12345678, -32'sh00345678, 32'sh0000_0001, 0, 0, 0, 1};
        send_word(a);
        for (int i = 0; i < 16; i++)
        begin
            a.vx = vext[i%4]; a.vy = vext[(i/4)%4]; a.vz = vext[(i+1)%4];
            a.qw = qext[i%4]; a.qx = qext[(i/4)%4]; a.qy = qext[(i+2)%4];
            a.qz = qext[(i+3)%4];
            send_word(a);
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_word(rand_word($urandom_range(0, 3) != 0));
    endtask

    task automatic test_backpressure();
        hold_cycles <= 120;
        test_random(80);
    endtask

    task automatic test_streaming();
        idle_on = 0;
        test_random(200);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_random(630);
        test_backpressure();
        test_streaming();
        s_tvalid <= 0;
        while (expected_rot.size() != 0)
            @(posedge clk);
        repeat (VW + 20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
